// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked outside reset.
`define BFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define BFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFL_ASSERT(lbl, prop, msg)
`define BFL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/bfl_pkg.sv =====
// Types, constants and type decode for the BSON field locator.
package bfl_pkg;

  localparam int unsigned MAX_NAME_BYTES_DEF = 16;
  localparam int unsigned OFFSET_BITS_DEF    = 24;

  localparam int unsigned OUT_OFS_W  = 24;
  localparam int unsigned NAME_IDX_W = 5;

  // configuration register indexes
  localparam logic [1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [1:0] REG_NAME_LEN  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  // size codes: fixed size below 0x80, length prefixed with extra in low bits
  localparam logic [7:0] SZ_LEN  = 8'h80;
  localparam logic [7:0] SZ_LEN4 = 8'h84;
  localparam logic [7:0] SZ_LEN5 = 8'h85;
  localparam logic [7:0] SZ_NONE = 8'hff;

  localparam logic [7:0] TYPE_STRING  = 8'd2;
  localparam logic [7:0] TYPE_BINDATA = 8'd5;
  localparam logic [7:0] TYPE_REGEX   = 8'd11;
  localparam logic [7:0] TYPE_DBREF   = 8'd12;
  localparam logic [7:0] TYPE_CODE    = 8'd13;
  localparam logic [7:0] TYPE_SYMBOL  = 8'd14;
  localparam logic [7:0] TYPE_CWS     = 8'd15;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_TYPE   = 4'd1,
    PH_NAME   = 4'd2,
    PH_LENGTH = 4'd3,
    PH_SKIP   = 4'd4,
    PH_REGEX1 = 4'd5,
    PH_REGEX2 = 4'd6,
    PH_IDLE   = 4'd7
  } phase_t;

  function automatic logic [7:0] size_code(input logic [7:0] t);
    logic [7:0] z;
    case (t)
      8'd0, 8'd6, 8'd10, 8'd127, 8'd255: z = 8'd0;
      8'd1, 8'd9, 8'd17, 8'd18:          z = 8'd8;
      8'd2:                              z = SZ_LEN4;
      8'd3, 8'd4:                        z = SZ_LEN;
      8'd5:                              z = SZ_LEN5;
      8'd7:                              z = 8'd12;
      8'd8:                              z = 8'd1;
      8'd16:                             z = 8'd4;
      default:                           z = SZ_NONE;
    endcase
    return z;
  endfunction

  // value size adjustment applied to the int32 length prefix
  function automatic logic signed [5:0] length_adjust(input logic [7:0] t);
    logic signed [5:0] a;
    case (t)
      TYPE_STRING, TYPE_CODE, TYPE_SYMBOL: a = 6'sd0;
      TYPE_BINDATA:                        a = 6'sd1;
      TYPE_DBREF:                          a = 6'sd12;
      default:                             a = -6'sd4;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/bson_field_locator.sv =====
// BSON field locator: streams a document byte by byte and reports one field lookup result.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one document byte per item,
//   doc_byte, with doc_last on the final byte of each document.
//   Output channel (out_valid/out_ready) gives exactly one result per document:
//   status (found, not found, unknown type, truncated) and, when found, the
//   offsets of the element's type byte and first value byte plus its type.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the target
//   name low/high bytes and length; cfg_ready is always high. Write it only
//   while no document is in flight.
// Timing:
//   One byte per cycle sustained. A result is registered and valid the cycle
//   after the byte that decides it. All decode sits between the walk state
//   registers and the result register; a byte is taken while a result waits
//   as long as out_ready is high, and stalls only if the result register is
//   full and not being drained.
// Reset: synchronous; target name clears to zero with length 1 and the walk
//   restarts at the document header. doc_last also restarts the walk.
`include "assert_macros.svh"

module bson_field_locator
  import bfl_pkg::*;
#(
  parameter int unsigned MAX_NAME_BYTES = MAX_NAME_BYTES_DEF,
  parameter int unsigned OFFSET_BITS    = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           doc_byte,
  input  logic                 doc_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [OUT_OFS_W-1:0] element_offset,
  output logic [7:0]           element_type,
  output logic [OUT_OFS_W-1:0] value_offset,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam logic [NAME_IDX_W-1:0] MAX_IDX = NAME_IDX_W'(MAX_NAME_BYTES);

  // configuration
  logic [63:0]           target_name_low;
  logic [63:0]           target_name_high;
  logic [NAME_IDX_W-1:0] target_name_length;

  // walk state
  phase_t                 phase, phase_next;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] element_start, element_start_next;
  logic [7:0]             current_type, current_type_next;
  logic [NAME_IDX_W-1:0]  name_index, name_index_next;
  logic                   name_mismatch, name_mismatch_next;
  logic [3:0][7:0]        length_accumulator, length_accumulator_next;
  logic [31:0]            skip_remaining, skip_remaining_next;
  logic                   result_sent;

  logic                   in_fire;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [NAME_IDX_W-1:0]  len_eff;
  logic [15:0][7:0]       tgt_arr;
  logic                   name_match;
  logic [7:0]             code;
  logic                   len_type;
  logic [31:0]            len_val;
  logic signed [5:0]      len_adj;
  logic [33:0]            len_sum;
  logic [31:0]            skip_len;
  logic                   emit;
  logic [1:0]             emit_status;
  logic                   emit_found;
  logic [OFFSET_BITS+OUT_OFS_W-1:0] start_ext;
  logic [OFFSET_BITS+OUT_OFS_W-1:0] value_ext;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign pos_inc   = byte_position + OFFSET_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_name_low    <= '0;
      target_name_high   <= '0;
      target_name_length <= NAME_IDX_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NAME_LOW:  target_name_low    <= cfg_data;
        REG_NAME_HIGH: target_name_high   <= cfg_data;
        REG_NAME_LEN:  target_name_length <= cfg_data[NAME_IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // decode shared by next-state and datapath logic
  assign len_eff    = (target_name_length > MAX_IDX) ? MAX_IDX : target_name_length;
  assign tgt_arr    = {target_name_high, target_name_low};
  assign name_match = !name_mismatch && (name_index == len_eff);
  assign code       = size_code(current_type);
  assign len_type   = (code != SZ_NONE) ||
                      (current_type >= TYPE_DBREF && current_type <= TYPE_CWS);
  assign len_val    = {doc_byte, length_accumulator[2], length_accumulator[1],
                       length_accumulator[0]};
  assign len_adj    = length_adjust(current_type);
  assign len_sum    = {{2{len_val[31]}}, len_val} + {{28{len_adj[5]}}, len_adj};
  // negative sizes skip nothing; above 32 bits saturates
  assign skip_len   = len_sum[33] ? 32'd0 : (len_sum[32] ? 32'hffff_ffff : len_sum[31:0]);

  always_comb begin
    phase_next = phase;
    if (!result_sent) begin
      case (phase)
        PH_HEADER: if (byte_position >= OFFSET_BITS'(3)) phase_next = PH_TYPE;
        PH_TYPE:   phase_next = (doc_byte == 8'd0) ? PH_IDLE : PH_NAME;
        PH_NAME: begin
          if (doc_byte == 8'd0 && !doc_last) begin
            if (name_match) phase_next = PH_IDLE;
            else if (!code[7]) phase_next = (code == 8'd0) ? PH_TYPE : PH_SKIP;
            else if (len_type) phase_next = PH_LENGTH;
            else if (current_type == TYPE_REGEX) phase_next = PH_REGEX1;
            else phase_next = PH_IDLE;
          end
        end
        PH_LENGTH: begin
          if (name_index[1:0] == 2'd3) phase_next = (skip_len == 32'd0) ? PH_TYPE : PH_SKIP;
        end
        PH_SKIP:   if (skip_remaining <= 32'd1) phase_next = PH_TYPE;
        PH_REGEX1: if (doc_byte == 8'd0) phase_next = PH_REGEX2;
        PH_REGEX2: if (doc_byte == 8'd0) phase_next = PH_TYPE;
        default: ;
      endcase
    end
    if (doc_last) phase_next = PH_HEADER;
  end

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_NOT_FOUND;
    emit_found  = 1'b0;
    if (!result_sent) begin
      if (phase == PH_TYPE && doc_byte == 8'd0) begin
        emit = 1'b1;
      end else if (phase == PH_NAME && doc_byte == 8'd0 && !doc_last) begin
        if (name_match) begin
          emit        = 1'b1;
          emit_status = ST_FOUND;
          emit_found  = 1'b1;
        end else if (code[7] && !len_type && current_type != TYPE_REGEX) begin
          emit        = 1'b1;
          emit_status = ST_BAD_TYPE;
        end
      end
      // end of document with nothing reported yet
      if (!emit && doc_last) begin
        emit        = 1'b1;
        emit_status = (phase == PH_TYPE) ? ST_NOT_FOUND : ST_TRUNCATED;
      end
    end
  end

  always_comb begin
    element_start_next      = element_start;
    current_type_next       = current_type;
    name_index_next         = name_index;
    name_mismatch_next      = name_mismatch;
    length_accumulator_next = length_accumulator;
    skip_remaining_next     = skip_remaining;
    if (!result_sent) begin
      case (phase)
        PH_TYPE: begin
          if (doc_byte != 8'd0) begin
            element_start_next = byte_position;
            current_type_next  = doc_byte;
            name_index_next    = '0;
            name_mismatch_next = 1'b0;
          end
        end
        PH_NAME: begin
          if (doc_byte != 8'd0) begin
            if (name_index >= len_eff || doc_byte != tgt_arr[name_index[3:0]]) begin
              name_mismatch_next = 1'b1;
            end
            if (name_index <= MAX_IDX) name_index_next = name_index + NAME_IDX_W'(1);
          end else if (!doc_last && !name_match) begin
            if (!code[7]) begin
              skip_remaining_next = {24'd0, code};
            end else if (len_type) begin
              length_accumulator_next = '0;
              name_index_next         = '0;
            end
          end
        end
        PH_LENGTH: begin
          length_accumulator_next[name_index[1:0]] = doc_byte;
          if (name_index[1:0] == 2'd3) begin
            name_index_next     = '0;
            skip_remaining_next = skip_len;
          end else begin
            name_index_next = name_index + NAME_IDX_W'(1);
          end
        end
        PH_SKIP: begin
          if (skip_remaining != 32'd0) skip_remaining_next = skip_remaining - 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      byte_position      <= '0;
      element_start      <= '0;
      current_type       <= '0;
      name_index         <= '0;
      name_mismatch      <= 1'b0;
      length_accumulator <= '0;
      skip_remaining     <= '0;
      result_sent        <= 1'b0;
    end else if (in_fire) begin
      phase <= phase_next;
      if (doc_last) begin
        byte_position      <= '0;
        element_start      <= '0;
        current_type       <= '0;
        name_index         <= '0;
        name_mismatch      <= 1'b0;
        length_accumulator <= '0;
        skip_remaining     <= '0;
        result_sent        <= 1'b0;
      end else begin
        byte_position      <= pos_inc;
        element_start      <= element_start_next;
        current_type       <= current_type_next;
        name_index         <= name_index_next;
        name_mismatch      <= name_mismatch_next;
        length_accumulator <= length_accumulator_next;
        skip_remaining     <= skip_remaining_next;
        result_sent        <= result_sent || emit;
      end
    end
  end

  // offsets wrap at OFFSET_BITS, then fit to the output width
  assign start_ext = {{OUT_OFS_W{1'b0}}, element_start};
  assign value_ext = {{OUT_OFS_W{1'b0}}, pos_inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      status         <= emit_status;
      element_offset <= emit_found ? start_ext[OUT_OFS_W-1:0] : '0;
      element_type   <= emit_found ? current_type : 8'd0;
      value_offset   <= emit_found ? value_ext[OUT_OFS_W-1:0] : '0;
    end
  end

  `BFL_ASSERT(a_sent_idle, result_sent == (phase == PH_IDLE), "result flag and idle phase disagree")
  `BFL_ASSERT(a_last_restart, in_fire && doc_last |=> phase == PH_HEADER && byte_position == '0 && !result_sent, "walk did not restart after last byte")
  `BFL_ASSERT(a_len_idx, phase == PH_LENGTH |-> name_index < NAME_IDX_W'(4), "length byte index out of range")
  `BFL_ASSERT(a_emit_sent, in_fire && emit && !doc_last |=> result_sent && out_valid, "result emitted without marking document done")
  `BFL_ASSERT_ALWAYS(a_one_result, in_fire && emit |-> !result_sent, "second result for one document")

endmodule

// ===== bench/bfl_lookup_checker.sv =====
// Result checker for the BSON field locator: follows the byte stream and compares each lookup.
`timescale 1ns / 1ps

package bfl_bench_pkg;
  import bfl_pkg::*;

  localparam logic [7:0] T_EOO       = 8'd0;
  localparam logic [7:0] T_DOUBLE    = 8'd1;
  localparam logic [7:0] T_OBJECT    = 8'd3;
  localparam logic [7:0] T_ARRAY     = 8'd4;
  localparam logic [7:0] T_UNDEF     = 8'd6;
  localparam logic [7:0] T_OID       = 8'd7;
  localparam logic [7:0] T_BOOL      = 8'd8;
  localparam logic [7:0] T_DATE      = 8'd9;
  localparam logic [7:0] T_NULL      = 8'd10;
  localparam logic [7:0] T_INT32     = 8'd16;
  localparam logic [7:0] T_TIMESTAMP = 8'd17;
  localparam logic [7:0] T_INT64     = 8'd18;
  localparam logic [7:0] T_MAXKEY    = 8'd127;
  localparam logic [7:0] T_MINKEY    = 8'd255;

  // index with no register behind it; writes must change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_OFS_W-1:0] element_offset;
    logic [7:0]           element_type;
    logic [OUT_OFS_W-1:0] value_offset;
  } lookup_t;

  // value bytes of fixed-size types, -1 for the rest
  function automatic int fixed_size(input logic [7:0] t);
    case (t)
      T_EOO, T_UNDEF, T_NULL, T_MAXKEY, T_MINKEY: return 0;
      T_DOUBLE, T_DATE, T_TIMESTAMP, T_INT64:     return 8;
      T_OID:                                      return 12;
      T_BOOL:                                     return 1;
      T_INT32:                                    return 4;
      default:                                    return -1;
    endcase
  endfunction

  function automatic bit is_length_prefixed(input logic [7:0] t);
    case (t)
      TYPE_STRING, T_OBJECT, T_ARRAY, TYPE_BINDATA,
      TYPE_DBREF, TYPE_CODE, TYPE_SYMBOL, TYPE_CWS: return 1'b1;
      default:                                      return 1'b0;
    endcase
  endfunction

  // value size = int32 prefix + extra, prefix included
  function automatic int prefix_extra(input logic [7:0] t);
    case (t)
      TYPE_STRING, TYPE_CODE, TYPE_SYMBOL: return 4;
      TYPE_BINDATA:                        return 5;
      TYPE_DBREF:                          return 16;
      default:                             return 0;
    endcase
  endfunction
endpackage

module bfl_lookup_checker
  import bfl_pkg::*;
  import bfl_bench_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           doc_byte,
  input  logic                 doc_last,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [1:0]           status,
  input  logic [OUT_OFS_W-1:0] element_offset,
  input  logic [7:0]           element_type,
  input  logic [OUT_OFS_W-1:0] value_offset,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  output int                   mismatches,
  output int                   awaited
);
  localparam longint SKIP_CAP = 64'h0000_0000_FFFF_FFFF;

  lookup_t expected_lookups[$];
  int      results_seen;

  logic [63:0] name_lo, name_hi;
  logic [4:0]  name_len;

  phase_t               walk;
  logic [OUT_OFS_W-1:0] pos_cnt, elem_pos;
  logic [7:0]           elem_type;
  logic [4:0]           count;
  logic                 name_diff;
  logic [31:0]          len_acc, skip_cnt;
  logic                 reported;

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic restart_doc();
    walk      = PH_HEADER;
    pos_cnt   = '0;
    elem_pos  = '0;
    elem_type = '0;
    count     = '0;
    name_diff = 1'b0;
    len_acc   = '0;
    skip_cnt  = '0;
    reported  = 1'b0;
  endtask

  task automatic post(input logic [1:0] st, input logic [OUT_OFS_W-1:0] eo,
                      input logic [7:0] ty, input logic [OUT_OFS_W-1:0] vo);
    lookup_t r;
    r.status         = st;
    r.element_offset = eo;
    r.element_type   = ty;
    r.value_offset   = vo;
    expected_lookups.push_back(r);
    awaited  = expected_lookups.size();
    reported = 1'b1;
    walk     = PH_IDLE;
  endtask

  task automatic begin_skip(input logic [31:0] n);
    skip_cnt = n;
    walk     = (n != 0) ? PH_SKIP : PH_TYPE;
  endtask

  function automatic logic [7:0] name_char(input logic [4:0] i);
    logic [63:0] w;
    w = (i < 8) ? name_lo : name_hi;
    return w[i[2:0]*8 +: 8];
  endfunction

  task automatic walk_byte(input logic [7:0] b, input logic last);
    phase_t entry;
    int     eff;
    int     sz;
    longint span;
    entry = walk;
    if (!reported) begin
      case (walk)
        PH_HEADER: if (pos_cnt >= 3) walk = PH_TYPE;
        PH_TYPE: begin
          if (b == T_EOO) post(ST_NOT_FOUND, '0, '0, '0);
          else begin
            elem_pos  = pos_cnt;
            elem_type = b;
            count     = '0;
            name_diff = 1'b0;
            walk      = PH_NAME;
          end
        end
        PH_NAME: begin
          eff = (name_len > MAX_NAME_BYTES_DEF) ? MAX_NAME_BYTES_DEF : name_len;
          if (b != 8'h00) begin
            if (count >= eff || b != name_char(count)) name_diff = 1'b1;
            if (count <= MAX_NAME_BYTES_DEF) count++;
          end else if (!last) begin
            // a matching name wins over any type check
            if (!name_diff && count == eff) begin
              post(ST_FOUND, elem_pos, elem_type, pos_cnt + 1'b1);
            end else begin
              sz = fixed_size(elem_type);
              if (sz >= 0) begin
                begin_skip(32'(sz));
              end else if (is_length_prefixed(elem_type)) begin
                len_acc = '0;
                count   = '0;
                walk    = PH_LENGTH;
              end else if (elem_type == TYPE_REGEX) begin
                walk = PH_REGEX1;
              end else begin
                post(ST_BAD_TYPE, '0, '0, '0);
              end
            end
          end
        end
        PH_LENGTH: begin
          len_acc = len_acc | (32'(b) << (count[1:0] * 8));
          count++;
          if (count >= 4) begin
            span = longint'(signed'(len_acc)) + prefix_extra(elem_type) - 4;
            if (span < 0) span = 0;
            if (span > SKIP_CAP) span = SKIP_CAP;
            count = '0;
            begin_skip(span[31:0]);
          end
        end
        PH_SKIP: begin
          if (skip_cnt != 0) skip_cnt--;
          if (skip_cnt == 0) walk = PH_TYPE;
        end
        PH_REGEX1: if (b == 8'h00) walk = PH_REGEX2;
        PH_REGEX2: if (b == 8'h00) walk = PH_TYPE;
        default: ;
      endcase
    end
    pos_cnt = pos_cnt + 1'b1;
    if (last) begin
      if (!reported) post((entry == PH_TYPE) ? ST_NOT_FOUND : ST_TRUNCATED, '0, '0, '0);
      restart_doc();
    end
  endtask

  task automatic check_result();
    lookup_t want;
    results_seen++;
    if (expected_lookups.size() == 0) begin
      note_mismatch($sformatf("result %0d arrived with none expected (status %0d)",
                              results_seen, status));
    end else begin
      want    = expected_lookups.pop_front();
      awaited = expected_lookups.size();
      if (status !== want.status)
        note_mismatch($sformatf("result %0d status %0d, want %0d",
                                results_seen, status, want.status));
      if (element_offset !== want.element_offset)
        note_mismatch($sformatf("result %0d element_offset %0d, want %0d",
                                results_seen, element_offset, want.element_offset));
      if (element_type !== want.element_type)
        note_mismatch($sformatf("result %0d element_type %0h, want %0h",
                                results_seen, element_type, want.element_type));
      if (value_offset !== want.value_offset)
        note_mismatch($sformatf("result %0d value_offset %0d, want %0d",
                                results_seen, value_offset, want.value_offset));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      name_lo  = '0;
      name_hi  = '0;
      name_len = 5'd1;
      restart_doc();
      expected_lookups.delete();
      awaited      = 0;
      results_seen = 0;
    end else begin
      // a result never comes from the byte taken at the same edge
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NAME_LOW:  name_lo  = cfg_data;
          REG_NAME_HIGH: name_hi  = cfg_data;
          REG_NAME_LEN:  name_len = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) walk_byte(doc_byte, doc_last);
    end
  end
endmodule

// ===== bench/bson_field_locator_test.sv =====
// Top of the BSON field locator bench: clock, reset, document stimulus and verdict.
`timescale 1ns / 1ps

module bson_field_locator_test
  import bfl_pkg::*;
  import bfl_bench_pkg::*;
();

  localparam int ITEM_GOAL    = 1950;
  localparam int PHASES       = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 300000;
  // a type code outside the BSON set
  localparam logic [7:0] T_PRIVATE = 8'h20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           doc_byte = 8'h00;
  logic                 doc_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [OUT_OFS_W-1:0] element_offset;
  logic [7:0]           element_type;
  logic [OUT_OFS_W-1:0] value_offset;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = REG_NAME_LOW;
  logic [63:0]          cfg_data = '0;

  int          mismatches;
  int          awaited;
  int unsigned cycles = 0;
  int          items_sent = 0;
  int          out_hold = 0;
  int          stall_draw;
  bit          calm = 1'b0;

  logic [7:0] doc_q[$];
  logic [7:0] target_bytes[16];
  int         target_len;

  bson_field_locator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .doc_byte(doc_byte), .doc_last(doc_last),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .element_offset(element_offset), .element_type(element_type),
    .value_offset(value_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bfl_lookup_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .doc_byte(doc_byte), .doc_last(doc_last),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .element_offset(element_offset), .element_type(element_type),
    .value_offset(value_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaited(awaited)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bson_field_locator verification failed");
      $finish;
    end
  end

  // result side: after a taken result, unless calm, drop ready for a drawn number of cycles or not at all
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else if (!out_ready) begin
      if (out_hold == 0) out_ready <= 1'b1;
      else out_hold <= out_hold - 1;
    end else if (out_valid && !calm) begin
      stall_draw = $urandom_range(0, 8);
      if (stall_draw != 0) begin
        out_ready <= 1'b0;
        out_hold  <= stall_draw - 1;
      end
    end
  end

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] pick_type();
    if ($urandom_range(0, 15) == 0)
      return ($urandom_range(0, 1) == 0) ? rand_byte(19, 126) : rand_byte(128, 254);
    case ($urandom_range(0, 19))
      0:  return T_DOUBLE;
      1:  return TYPE_STRING;
      2:  return T_OBJECT;
      3:  return T_ARRAY;
      4:  return TYPE_BINDATA;
      5:  return T_UNDEF;
      6:  return T_OID;
      7:  return T_BOOL;
      8:  return T_DATE;
      9:  return T_NULL;
      10: return TYPE_REGEX;
      11: return TYPE_DBREF;
      12: return TYPE_CODE;
      13: return TYPE_SYMBOL;
      14: return TYPE_CWS;
      15: return T_INT32;
      16: return T_TIMESTAMP;
      17: return T_INT64;
      18: return T_MAXKEY;
      default: return T_MINKEY;
    endcase
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    doc_byte <= b;
    doc_last <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_doc();
    int i;
    for (i = 0; i < doc_q.size(); i++) drive_byte(doc_q[i], i == doc_q.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_target(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [63:0] len_word, input bit touch_spare);
    int i;
    cfg_put(REG_NAME_LOW, lo);
    cfg_put(REG_NAME_HIGH, hi);
    cfg_put(REG_NAME_LEN, len_word);
    if (touch_spare) cfg_put(REG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    for (i = 0; i < 8; i++) begin
      target_bytes[i]     = lo[i*8 +: 8];
      target_bytes[i + 8] = hi[i*8 +: 8];
    end
    target_len = len_word[4:0];
  endtask

  // exact target name, near misses, or a random name up to past the name limit
  task automatic add_name();
    int eff, kind, k;
    eff  = (target_len > 16) ? 16 : target_len;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      for (k = 0; k < eff; k++) doc_q.push_back(target_bytes[k]);
      if (kind == 4 && eff > 0) begin
        void'(doc_q.pop_back());
      end else if (kind == 5) begin
        doc_q.push_back(rand_byte(1, 255));
      end else if (kind == 6 && eff > 0) begin
        k = doc_q.size() - 1 - $urandom_range(0, eff - 1);
        doc_q[k] = doc_q[k] ^ rand_byte(1, 255);
      end
    end else begin
      repeat ($urandom_range(0, 18)) doc_q.push_back(rand_byte(1, 255));
    end
    doc_q.push_back(8'h00);
  endtask

  task automatic add_value(input logic [7:0] t, input bit bad_len);
    int          size, body, i;
    logic [31:0] plen;
    size = fixed_size(t);
    if (size >= 0) begin
      repeat (size) doc_q.push_back(rand_byte(0, 255));
    end else if (is_length_prefixed(t)) begin
      body = $urandom_range(0, 6);
      plen = 32'(body + 4 - prefix_extra(t));
      if (bad_len) begin
        case ($urandom_range(0, 4))
          0: plen = 32'h8000_0000;
          1: plen = 32'hFFFF_FFFF;
          2: plen = 32'h0000_0000;
          3: plen = 32'h7FFF_FFFF;
          default: plen = $urandom;
        endcase
      end
      for (i = 0; i < 4; i++) doc_q.push_back(plen[i*8 +: 8]);
      repeat (body) doc_q.push_back(rand_byte(0, 255));
    end else if (t == TYPE_REGEX) begin
      repeat (2) begin
        repeat ($urandom_range(0, 4)) doc_q.push_back(rand_byte(1, 255));
        doc_q.push_back(8'h00);
      end
    end else begin
      repeat ($urandom_range(0, 3)) doc_q.push_back(rand_byte(0, 255));
    end
  endtask

  // mostly well-formed documents; some noise, trailing junk, cut-off or bad lengths
  task automatic make_doc();
    int         mode, cut;
    logic [7:0] t;
    doc_q.delete();
    calm = ($urandom_range(0, 5) == 0);
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      repeat ($urandom_range(1, 24)) doc_q.push_back(rand_byte(0, 255));
    end else begin
      repeat (4) doc_q.push_back(rand_byte(0, 255));
      repeat ($urandom_range(0, 4)) begin
        t = pick_type();
        doc_q.push_back(t);
        add_name();
        add_value(t, mode >= 80 && $urandom_range(0, 2) == 0);
      end
      doc_q.push_back(T_EOO);
      if (mode < 20) begin
        repeat ($urandom_range(1, 6)) doc_q.push_back(rand_byte(0, 255));
      end else if (mode < 36) begin
        cut = $urandom_range(1, doc_q.size() - 1);
        while (doc_q.size() > cut) void'(doc_q.pop_back());
      end
    end
  endtask

  initial begin
    int          p, i, len;
    logic [63:0] lo, hi, len_word;
    target_bytes = '{default: 8'h00};
    target_len   = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset target: cut inside the header, then an empty document
    doc_q = '{8'hFF, 8'hFF, 8'hFF};
    send_doc();
    doc_q = '{8'h00, 8'h00, 8'h00, 8'h00, T_EOO};
    send_doc();

    wait_idle();
    load_target(64'h6261, 64'h0, 64'd2, 1'b1);
    // match on an unknown type, then a miss on it, then end on a type byte
    doc_q = '{8'h00, 8'h00, 8'h00, 8'h00, T_PRIVATE, 8'h61, 8'h62, 8'h00, 8'h00};
    send_doc();
    doc_q = '{8'h00, 8'h00, 8'h00, 8'h00, T_PRIVATE, 8'h78, 8'h00, T_EOO};
    send_doc();
    doc_q = '{8'h00, 8'h00, 8'h00, 8'h00, T_INT32};
    send_doc();

    for (p = 0; p < PHASES; p++) begin
      for (i = 0; i < 8; i++) begin
        lo[i*8 +: 8] = rand_byte(1, 255);
        hi[i*8 +: 8] = rand_byte(1, 255);
      end
      case (p)
        0: len = 1;
        1: len = 16;
        2: len = 0;
        3: len = 17;
        4: begin
          len = 31;
          lo  = '1;
          hi  = '1;
        end
        5: len = $urandom_range(2, 15);
        6: len = 9;
        default: begin
          len = $urandom_range(1, 16);
          lo  = {$urandom, $urandom};
          hi  = '0;
        end
      endcase
      len_word      = {$urandom, $urandom};
      len_word[4:0] = 5'(len);
      wait_idle();
      load_target(lo, hi, len_word, p == 3);
      while (items_sent < (p + 1) * ITEM_GOAL / PHASES) begin
        make_doc();
        send_doc();
      end
    end

    calm = 1'b0;
    wait_idle();
    if (mismatches == 0 && awaited == 0) begin
      $display("bson_field_locator verification clean");
    end else begin
      $display("bson_field_locator verification failed");
    end
    $finish;
  end
endmodule
